FILE: hw/rtl/framed_packet_receiver_sum_xor_macros.svh
// ---------------------------------------------------------------------------
// framed packet receiver assertion macros
// shared assertion helpers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_SUM_XOR_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_SUM_XOR_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FPRX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define FPRX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPRX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FPRX_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/fprx_pkg.sv
// ---------------------------------------------------------------------------
// fprx_pkg
// shared constants for the framed packet receiver
// ---------------------------------------------------------------------------
package fprx_pkg;

    localparam int unsigned PAYLOAD_LEN_DEF = 3;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned CFG_IDX_W       = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 1'd1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hAA;

    // parser phases
    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_HUNT1 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT2 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SUM   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_XOR   = 3'd4;

endpackage

FILE: hw/rtl/fprx_if.sv
// ---------------------------------------------------------------------------
// fprx channel interfaces
// valid/ready channels for received bytes, results and configuration
// ---------------------------------------------------------------------------
interface fprx_rx_if;
    logic                          valid;
    logic                          ready;
    logic [fprx_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fprx_result_if;
    logic                          valid;
    logic                          ready;
    logic [fprx_pkg::BYTE_W-1:0]   payload_byte;
    logic                          last_of_frame;

    modport source (output valid, output payload_byte, output last_of_frame, input ready);
    modport sink   (input valid, input payload_byte, input last_of_frame, output ready);
endinterface

interface fprx_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fprx_pkg::CFG_IDX_W-1:0]   index;
    logic [fprx_pkg::BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/fprx_parser.sv
// ---------------------------------------------------------------------------
// fprx_parser
// header hunt, payload capture, sum/xor check; one byte per cycle if rx_ready
// ---------------------------------------------------------------------------
module fprx_parser #(
    parameter int unsigned PAYLOAD_LEN = fprx_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    rx_valid,
    output logic                                    rx_ready,
    input  logic [fprx_pkg::BYTE_W-1:0]             rx_byte,
    input  logic                                    cfg_valid,
    input  logic [fprx_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [fprx_pkg::BYTE_W-1:0]             cfg_data,
    input  logic                                    buf_free,
    output logic                                    load,
    output logic [PAYLOAD_LEN*fprx_pkg::BYTE_W-1:0] frame
);

    localparam int unsigned CNT_W = $clog2(PAYLOAD_LEN + 1);
    localparam int unsigned BW    = fprx_pkg::BYTE_W;

    logic [fprx_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [BW-1:0]                sum_reg, sum_next;
    logic [BW-1:0]                xor_reg, xor_next;
    logic [BW-1:0]                hdr1_reg, hdr2_reg;
    logic [BW-1:0]                store_reg [PAYLOAD_LEN];
    logic                         accept;

    // only the xor byte of a frame can need the result buffer
    assign rx_ready = (phase_reg != fprx_pkg::PH_XOR) || buf_free;
    assign accept   = rx_valid && rx_ready;
    assign load     = accept && (phase_reg == fprx_pkg::PH_XOR) && (rx_byte == xor_reg);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        xor_next   = xor_reg;
        unique case (phase_reg)
            fprx_pkg::PH_HUNT1:
            begin
                if (rx_byte == hdr1_reg)
                    phase_next = fprx_pkg::PH_HUNT2;
            end
            fprx_pkg::PH_HUNT2:
            begin
                if (rx_byte == hdr2_reg)
                begin
                    phase_next = fprx_pkg::PH_DATA;
                    count_next = '0;
                    sum_next   = '0;
                    xor_next   = '0;
                end
                else
                begin
                    phase_next = fprx_pkg::PH_HUNT1;
                end
            end
            fprx_pkg::PH_DATA:
            begin
                sum_next   = sum_reg + rx_byte;
                xor_next   = xor_reg ^ rx_byte;
                count_next = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(PAYLOAD_LEN - 1))
                    phase_next = fprx_pkg::PH_SUM;
            end
            fprx_pkg::PH_SUM:
            begin
                phase_next = (rx_byte == sum_reg) ? fprx_pkg::PH_XOR : fprx_pkg::PH_HUNT1;
            end
            fprx_pkg::PH_XOR:
            begin
                phase_next = fprx_pkg::PH_HUNT1;
                count_next = '0;
                sum_next   = '0;
                xor_next   = '0;
            end
            default:
            begin
                phase_next = fprx_pkg::PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fprx_pkg::PH_HUNT1;
            count_reg <= '0;
            sum_reg   <= '0;
            xor_reg   <= '0;
            hdr1_reg  <= fprx_pkg::HEADER_FIRST_RST;
            hdr2_reg  <= fprx_pkg::HEADER_SECOND_RST;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
                xor_reg   <= xor_next;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    fprx_pkg::CFG_HEADER_FIRST:  hdr1_reg <= cfg_data;
                    fprx_pkg::CFG_HEADER_SECOND: hdr2_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload shift line, first byte ends up at the bottom
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == fprx_pkg::PH_DATA))
        begin
            for (int i = 0; i < int'(PAYLOAD_LEN) - 1; i++)
                store_reg[i] <= store_reg[i+1];
            store_reg[PAYLOAD_LEN-1] <= rx_byte;
        end
    end

    always_comb
    begin
        for (int i = 0; i < int'(PAYLOAD_LEN); i++)
            frame[i*BW +: BW] = store_reg[i];
    end

endmodule

FILE: hw/rtl/fprx_out_buf.sv
// ---------------------------------------------------------------------------
// fprx_out_buf
// result buffer, takes a whole checked frame and hands it out a word at a time
// ---------------------------------------------------------------------------
module fprx_out_buf #(
    parameter int unsigned PAYLOAD_LEN = fprx_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic [PAYLOAD_LEN*fprx_pkg::BYTE_W-1:0] frame,
    output logic                                    buf_free,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [fprx_pkg::BYTE_W-1:0]             payload_byte,
    output logic                                    last_of_frame
);

    localparam int unsigned CNT_W = $clog2(PAYLOAD_LEN + 1);
    localparam int unsigned BW    = fprx_pkg::BYTE_W;

    logic [CNT_W-1:0] left_reg;
    logic [BW-1:0]    data_reg [PAYLOAD_LEN];
    logic             pop;

    assign out_valid     = (left_reg != '0);
    assign pop           = out_valid && out_ready;
    assign payload_byte  = data_reg[0];
    assign last_of_frame = (left_reg == CNT_W'(1));
    // free when empty or the last word leaves this cycle
    assign buf_free      = !out_valid || (last_of_frame && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (load)
            left_reg <= CNT_W'(PAYLOAD_LEN);
        else if (pop)
            left_reg <= left_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < int'(PAYLOAD_LEN); i++)
                data_reg[i] <= frame[i*BW +: BW];
        end
        else if (pop)
        begin
            for (int i = 0; i < int'(PAYLOAD_LEN) - 1; i++)
                data_reg[i] <= data_reg[i+1];
        end
    end

endmodule

FILE: hw/rtl/framed_packet_receiver_sum_xor.sv
// ---------------------------------------------------------------------------
// framed_packet_receiver_sum_xor
// header hunt, payload capture and sum / xor checked frame output
// ---------------------------------------------------------------------------
// Takes one received byte per clock cycle. A frame is header_first, header_second,
// PAYLOAD_LEN payload bytes, an 8-bit wrapping sum byte and an xor byte. Each
// byte is handled in the cycle it is accepted. When the xor byte completes a good
// frame the payload moves into the result buffer in one go and leaves one word per
// cycle unless stalled, the final word marked by last_of_frame; bad frames produce
// nothing. rx.ready drops only while an xor byte is offered and the result buffer
// still holds words of the previous frame, unless all that is left is its last
// word and that word leaves in the same cycle. With a sink that keeps ready high
// the buffer is empty long before the next xor byte, so the block takes a byte
// every cycle. Configuration writes are always taken and belong in idle periods.
`include "framed_packet_receiver_sum_xor_macros.svh"

module framed_packet_receiver_sum_xor #(
    parameter int unsigned PAYLOAD_LEN = fprx_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    fprx_rx_if.sink              rx,
    fprx_result_if.source        result,
    fprx_cfg_if.sink             cfg
);

    logic                                    load;
    logic                                    buf_free;
    logic [PAYLOAD_LEN*fprx_pkg::BYTE_W-1:0] frame;

    assign cfg.ready = 1'b1;

    fprx_parser #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx.valid),
        .rx_ready  (rx.ready),
        .rx_byte   (rx.rx_byte),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .buf_free  (buf_free),
        .load      (load),
        .frame     (frame)
    );

    fprx_out_buf #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .frame         (frame),
        .buf_free      (buf_free),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .payload_byte  (result.payload_byte),
        .last_of_frame (result.last_of_frame)
    );

    // a frame never lands on results still pending
    `FPRX_ASSERT_IMP(a_load_when_free, clk, rst_n, load, buf_free)
    // a loaded frame is offered straight away
    `FPRX_ASSERT_NXT(a_load_shows, clk, rst_n, load, result.valid)
    // input only stalls behind pending results
    `FPRX_ASSERT_IMP(a_stall_cause, clk, rst_n, !rx.ready, result.valid)
    // the marked word empties the buffer
    `FPRX_ASSERT_NXT(a_last_drains, clk, rst_n,
        result.valid && result.ready && result.last_of_frame && !load, !result.valid)

endmodule

FILE: tb/sv/fprx_frame_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fprx_frame_checker
// watches the byte, result and register channels of the framed packet
// receiver, tracks the frame parser state on its own and compares every
// accepted result word with the oldest predicted word
// ---------------------------------------------------------------------------
module fprx_frame_checker
    import fprx_pkg::*;
#(
    parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fprx_rx_if          rx,
    fprx_result_if      result,
    fprx_cfg_if         cfg,
    output int unsigned fail_count,
    output int unsigned words_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_frame;
    } frame_word_t;

    frame_word_t        expected_words[$];

    logic [BYTE_W-1:0]  hdr_first;
    logic [BYTE_W-1:0]  hdr_second;
    logic [PHASE_W-1:0] phase;
    int unsigned        data_count;
    logic [BYTE_W-1:0]  sum_acc;
    logic [BYTE_W-1:0]  xor_acc;
    logic [BYTE_W-1:0]  frame_bytes [PAYLOAD_LEN];

    // advances the parser by one byte and queues the words of a good frame
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        frame_word_t w;
        case (phase)
            PH_HUNT1:
            begin
                if (b == hdr_first)
                    phase = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                // a wrong second byte restarts the hunt without being checked as a first byte
                if (b == hdr_second)
                begin
                    phase      = PH_DATA;
                    data_count = 0;
                    sum_acc    = '0;
                    xor_acc    = '0;
                end
                else
                    phase = PH_HUNT1;
            end
            PH_DATA:
            begin
                if (data_count < PAYLOAD_LEN)
                    frame_bytes[data_count] = b;
                sum_acc    = sum_acc + b;
                xor_acc    = xor_acc ^ b;
                data_count = data_count + 1;
                if (data_count >= PAYLOAD_LEN)
                    phase = PH_SUM;
            end
            PH_SUM:
            begin
                phase = (b == sum_acc) ? PH_XOR : PH_HUNT1;
            end
            PH_XOR:
            begin
                if (b == xor_acc)
                begin
                    for (int unsigned i = 0; i < PAYLOAD_LEN; i++)
                    begin
                        w.payload_byte  = frame_bytes[i];
                        w.last_of_frame = (i + 1 == PAYLOAD_LEN);
                        expected_words.push_back(w);
                    end
                end
                phase      = PH_HUNT1;
                data_count = 0;
                sum_acc    = '0;
                xor_acc    = '0;
            end
            default:
            begin
                phase = PH_HUNT1;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        frame_word_t w;
        if (!rst_n)
        begin
            hdr_first  = HEADER_FIRST_RST;
            hdr_second = HEADER_SECOND_RST;
            phase      = PH_HUNT1;
            data_count = 0;
            sum_acc    = '0;
            xor_acc    = '0;
            for (int unsigned i = 0; i < PAYLOAD_LEN; i++)
                frame_bytes[i] = '0;
            expected_words.delete();
            words_pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_HEADER_FIRST)
                    hdr_first = cfg.data;
                else if (cfg.index == CFG_HEADER_SECOND)
                    hdr_second = cfg.data;
            end
            // result words taken here always belong to earlier bytes
            if (result.valid && result.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: payload_byte %02h last_of_frame %0b",
                           result.payload_byte, result.last_of_frame);
                    fail_count++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (result.payload_byte !== w.payload_byte)
                    begin
                        $error("payload_byte: expected %02h actual %02h",
                               w.payload_byte, result.payload_byte);
                        fail_count++;
                    end
                    if (result.last_of_frame !== w.last_of_frame)
                    begin
                        $error("last_of_frame: expected %0b actual %0b",
                               w.last_of_frame, result.last_of_frame);
                        fail_count++;
                    end
                end
            end
            if (rx.valid && rx.ready)
                parse_byte(rx.rx_byte);
            words_pending = expected_words.size();
        end
    end

    initial
    begin
        fail_count    = 0;
        words_pending = 0;
    end

endmodule

FILE: tb/sv/framed_packet_receiver_sum_xor_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// framed_packet_receiver_sum_xor_tb
// drives framed byte streams with random gaps and back-pressure through
// several header settings; a side checker predicts and compares the output
// ---------------------------------------------------------------------------
module framed_packet_receiver_sum_xor_tb;
    import fprx_pkg::*;

    localparam int unsigned PAYLOAD_LEN  = PAYLOAD_LEN_DEF;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned SEG_BYTES    = 70;
    localparam int unsigned NUM_SEGS     = 6;

    // frame faults
    localparam int FAULT_NONE   = 0;
    localparam int FAULT_SUM    = 1;
    localparam int FAULT_XOR    = 2;
    localparam int FAULT_HEADER = 3;

    typedef logic [BYTE_W-1:0] payload_t [PAYLOAD_LEN];

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned words_pending;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned bytes_sent;
    logic [BYTE_W-1:0] cur_first;
    logic [BYTE_W-1:0] cur_second;

    fprx_rx_if     rx_ch ();
    fprx_result_if res_ch ();
    fprx_cfg_if    cfg_ch ();

    framed_packet_receiver_sum_xor #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    fprx_frame_checker #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_ch),
        .result        (res_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input payload_t payload, input int fault);
        logic [BYTE_W-1:0] sum_byte;
        logic [BYTE_W-1:0] xor_byte;
        sum_byte = '0;
        xor_byte = '0;
        for (int unsigned i = 0; i < PAYLOAD_LEN; i++)
        begin
            sum_byte = sum_byte + payload[i];
            xor_byte = xor_byte ^ payload[i];
        end
        if (fault == FAULT_SUM)
            sum_byte = sum_byte ^ BYTE_W'($urandom_range(1, 255));
        if (fault == FAULT_XOR)
            xor_byte = xor_byte ^ BYTE_W'($urandom_range(1, 255));
        send_byte(cur_first);
        if (fault == FAULT_HEADER)
            send_byte(cur_second ^ BYTE_W'($urandom_range(1, 255)));
        else
            send_byte(cur_second);
        for (int unsigned i = 0; i < PAYLOAD_LEN; i++)
            send_byte(payload[i]);
        send_byte(sum_byte);
        send_byte(xor_byte);
    endtask

    // only called with the result channel drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_HEADER_FIRST)
            cur_first = value;
        else
            cur_second = value;
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        wait (words_pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        else
            return BYTE_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[framed_packet_receiver_sum_xor] ERROR");
        $finish;
    end

    initial
    begin
        payload_t    pl;
        int unsigned seg_end;
        int unsigned r;
        int          fault;
        logic [BYTE_W-1:0] seg_first [NUM_SEGS];
        logic [BYTE_W-1:0] seg_second [NUM_SEGS];

        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_HEADER_FIRST;
        cfg_ch.data    = '0;
        res_ch.ready   = 1'b1;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        bytes_sent     = 0;
        cur_first      = HEADER_FIRST_RST;
        cur_second     = HEADER_SECOND_RST;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part with reset headers
        // repeated first header byte does not open a frame
        send_byte(cur_first);
        send_byte(cur_first);
        send_frame('{8'h00, 8'hFF, 8'h80}, FAULT_NONE);
        // failed sum must not leave the accumulators stale
        send_frame('{8'h12, 8'h34, 8'h56}, FAULT_SUM);
        send_frame('{8'hFF, 8'hFF, 8'hFF}, FAULT_NONE);
        send_frame('{8'hA5, 8'h5A, 8'h01}, FAULT_XOR);

        seg_first  = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'h55, 8'h00};
        seg_second = '{8'hFF, 8'h00, 8'h5A, 8'h00, 8'hAA, 8'h00};
        seg_first[3]  = BYTE_W'($urandom_range(0, 255));
        seg_second[3] = BYTE_W'($urandom_range(0, 255));
        seg_first[5]  = BYTE_W'($urandom_range(0, 255));
        seg_second[5] = BYTE_W'($urandom_range(0, 255));

        for (int unsigned seg = 0; seg < NUM_SEGS; seg++)
        begin
            wait_idle();
            write_reg(CFG_HEADER_FIRST, seg_first[seg]);
            write_reg(CFG_HEADER_SECOND, seg_second[seg]);
            case (seg % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 86; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 86; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            seg_end = bytes_sent + SEG_BYTES;
            while (bytes_sent < seg_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    // noise, now and then a lone first header byte
                    if ($urandom_range(0, 9) < 3)
                        send_byte(cur_first);
                    else
                        send_byte(rand_byte());
                end
                else
                begin
                    for (int unsigned i = 0; i < PAYLOAD_LEN; i++)
                        pl[i] = rand_byte();
                    if ($urandom_range(0, 99) < 70)
                        fault = FAULT_NONE;
                    else
                        fault = $urandom_range(FAULT_SUM, FAULT_HEADER);
                    send_frame(pl, fault);
                end
            end
        end

        rx_ch.valid <= 1'b0;
        wait (words_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[framed_packet_receiver_sum_xor] OK");
        else
            $display("[framed_packet_receiver_sum_xor] ERROR");
        $finish;
    end

endmodule
